// ----- sv/bearing_turn_in_place_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the turn-in-place bearing block
// Shared property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef BEARING_TURN_IN_PLACE_TOP_DEFINES_SVH
`define BEARING_TURN_IN_PLACE_TOP_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define BTIP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define BTIP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/btip_pkg.sv -----
// ----------------------------------------------------------------------------
// Turn-in-place bearing package
// Shared constants, the arctangent table and pipeline types.
// ----------------------------------------------------------------------------
package btip_pkg;

  localparam int ANGLE_FRAC_SCALE_DEF = 100;
  localparam int CORDIC_STEPS = 23;
  localparam int CW = 36;          // CORDIC datapath width
  localparam int ZW = 24;          // angle accumulator width, 1/65536 degree
  localparam logic signed [ZW-1:0] Z_MAX = ZW'(90 * 65536);

  localparam logic [1:0] REG_GOAL_X = 2'd0;
  localparam logic [1:0] REG_GOAL_Y = 2'd1;
  localparam logic [1:0] REG_YAW_TOL = 2'd2;
  localparam logic [1:0] REG_TURN_RATE = 2'd3;

  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 24'sd2949120;  1: v = 24'sd1740967;  2: v = 24'sd919879;
      3: v = 24'sd466945;   4: v = 24'sd234379;   5: v = 24'sd117304;
      6: v = 24'sd58666;    7: v = 24'sd29335;    8: v = 24'sd14668;
      9: v = 24'sd7334;     10: v = 24'sd3667;    11: v = 24'sd1833;
      12: v = 24'sd917;     13: v = 24'sd458;     14: v = 24'sd229;
      15: v = 24'sd115;     16: v = 24'sd57;      17: v = 24'sd29;
      18: v = 24'sd14;      19: v = 24'sd7;       20: v = 24'sd4;
      21: v = 24'sd2;       22: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Sideband carried beside the CORDIC lanes.
  typedef struct packed {
    logic        at_goal;
    logic [1:0]  quad;      // 0:90 1:180 2:270 3:360
    logic signed [16:0] heading;
  } side_t;

endpackage

// ----- sv/btip_cordic.sv -----
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// One micro-rotation per register stage, stall holds every stage.
// ----------------------------------------------------------------------------
module btip_cordic (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic [16:0]                num,
  input  logic [16:0]                den,
  input  btip_pkg::side_t            in_side,
  output logic                       out_vld,
  output logic signed [btip_pkg::ZW-1:0] z_out,
  output btip_pkg::side_t            out_side
);
  import btip_pkg::*;

  localparam int N = CORDIC_STEPS;
  logic signed [CW-1:0] x0, y0;
  logic signed [CW-1:0] x_r [1:N];
  logic signed [CW-1:0] y_r [1:N];
  logic signed [ZW-1:0] z_r [1:N];
  side_t                s_r [1:N];
  logic                 v_r [1:N];

  assign x0 = $signed({5'b0, den, 14'b0});
  assign y0 = $signed({5'b0, num, 14'b0});

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] x_in, y_in, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_in, z_nxt;
    side_t                s_in;
    logic                 v_in;
    if (i == 0) begin : g_first
      assign x_in = x0;
      assign y_in = y0;
      assign z_in = '0;
      assign s_in = in_side;
      assign v_in = in_vld;
    end else begin : g_next
      assign x_in = x_r[i];
      assign y_in = y_r[i];
      assign z_in = z_r[i];
      assign s_in = s_r[i];
      assign v_in = v_r[i];
    end
    always_comb begin
      if (!y_in[CW-1]) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + atan_lut(i);
      end else begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - atan_lut(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_in;
      end
      if (adv) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
        s_r[i+1] <= s_in;
      end
    end
  end

  assign out_vld  = v_r[N];
  assign z_out    = z_r[N];
  assign out_side = s_r[N];
endmodule

// ----- sv/btip_post.sv -----
// ----------------------------------------------------------------------------
// Bearing post-processing
// Clamp and scale the angle, apply quadrant, form error and command.
// ----------------------------------------------------------------------------
module btip_post #(
  parameter int ANGLE_FRAC_SCALE = btip_pkg::ANGLE_FRAC_SCALE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic signed [btip_pkg::ZW-1:0] z_in,
  input  btip_pkg::side_t            in_side,
  input  logic [14:0]                yaw_tol,
  input  logic [14:0]                rate,
  output logic                       out_vld,
  output logic [15:0]                bearing,
  output logic signed [17:0]         yaw_error,
  output logic                       aligned,
  output logic signed [15:0]         angular_speed
);
  import btip_pkg::*;

  localparam int SW = $clog2(ANGLE_FRAC_SCALE + 1);
  localparam int PW = ZW + SW;
  localparam int BW0 = $clog2(360 * ANGLE_FRAC_SCALE + 1) + 1;
  // Keep at least 16 magnitude bits so the bearing can always be sliced out.
  localparam int BW = (BW0 < 17) ? 17 : BW0;

  // Stage A: clamp and multiply.
  logic [ZW-1:0] zc;
  logic [PW-1:0] prod_r;
  side_t         sa_r;
  logic          va_r;
  always_comb begin
    if (z_in < 0) zc = '0;
    else if (z_in > Z_MAX) zc = Z_MAX;
    else zc = z_in;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= in_vld;
    if (adv) begin
      prod_r <= PW'(zc) * PW'(ANGLE_FRAC_SCALE);
      sa_r   <= in_side;
    end
  end

  // Stage B: round, quadrant, bearing.
  logic [PW-1:0]        rnd;
  logic [PW-17:0]       a_val;
  logic signed [BW:0]   base, brg;
  logic [15:0]          b_nxt, b_r;
  logic signed [16:0]   hd_r;
  logic                 vb_r;
  always_comb begin
    rnd   = prod_r + PW'(32768);
    a_val = rnd[PW-1:16];
    case (sa_r.quad)
      2'd0: base = (BW+1)'(90 * ANGLE_FRAC_SCALE);
      2'd1: base = (BW+1)'(180 * ANGLE_FRAC_SCALE);
      2'd2: base = (BW+1)'(270 * ANGLE_FRAC_SCALE);
      default: base = (BW+1)'(360 * ANGLE_FRAC_SCALE);
    endcase
    brg = base - $signed((BW+1)'(a_val));
    if (sa_r.at_goal || brg < 0) b_nxt = '0;
    else b_nxt = brg[15:0];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
    if (adv) begin
      b_r  <= b_nxt;
      hd_r <= sa_r.heading;
    end
  end

  // Stage C: error, alignment and command.
  logic signed [17:0] err;
  logic [17:0]        aerr;
  logic               vc_r, al_r;
  logic [15:0]        bo_r;
  logic signed [17:0] eo_r;
  logic signed [15:0] sp_r;
  always_comb begin
    err  = $signed({2'b0, b_r}) - 18'(hd_r);
    aerr = err[17] ? 18'(-err) : 18'(err);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
    if (adv) begin
      bo_r <= b_r;
      eo_r <= err;
      al_r <= (aerr <= 18'(yaw_tol));
      sp_r <= err[17] ? -$signed({1'b0, rate}) : $signed({1'b0, rate});
    end
  end

  assign out_vld       = vc_r;
  assign bearing       = bo_r;
  assign yaw_error     = eo_r;
  assign aligned       = al_r;
  assign angular_speed = sp_r;
endmodule

// ----- sv/bearing_turn_in_place_top.sv -----
// ----------------------------------------------------------------------------
// Turn-in-place bearing block, top level
// Bearing toward a goal point, yaw error and turn command per position word.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_stall) carries one word with the robot
// position and heading. The output channel (out_valid/out_stall) returns one
// word per input with bearing, unwrapped yaw error, aligned flag and turn
// command. Goal, tolerance and turn rate are written on the cfg_ port, which
// is always ready; write it only while no word is in flight.
// Stages: one input register, 23 CORDIC micro-rotation stages and three
// post-processing stages. Throughput is one word per cycle while the receiver
// does not stall, set by the fully pipelined CORDIC (one rotation per stage).
// Reset clears all valid bits and loads the register defaults: goal at the
// origin, tolerance 500, turn rate 100.
// When the receiver stalls a finished word, the whole pipeline freezes. in_stall
// is raised only when the last stage holds a word that is stalled, so no word
// is lost or repeated, and the input keeps flowing while that stage is empty.
module bearing_turn_in_place_top #(
  parameter int ANGLE_FRAC_SCALE = btip_pkg::ANGLE_FRAC_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [16:0] in_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_bearing,
  output logic signed [17:0] out_yaw_error,
  output logic               out_aligned,
  output logic signed [15:0] out_angular_speed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import btip_pkg::*;
  `include "bearing_turn_in_place_top_defines.svh"

  logic signed [15:0] goal_x_r, goal_y_r;
  logic [14:0]        yaw_tol_r, rate_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r  <= '0;
      goal_y_r  <= '0;
      yaw_tol_r <= 15'd500;
      rate_r    <= 15'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GOAL_X:    goal_x_r  <= cfg_data;
        REG_GOAL_Y:    goal_y_r  <= cfg_data;
        REG_YAW_TOL:   yaw_tol_r <= cfg_data[14:0];
        REG_TURN_RATE: rate_r    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a finished word waits on a stalled receiver.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input stage: differences, magnitudes and quadrant.
  logic signed [16:0] dx, dy;
  logic [16:0]        adx_r, ady_r;
  side_t              side_nxt, side_r;
  logic               v0_r;
  always_comb begin
    dx = 17'(goal_x_r) - 17'(in_pos_x);
    dy = 17'(goal_y_r) - 17'(in_pos_y);
    side_nxt.at_goal = (dx == '0) && (dy == '0);
    side_nxt.heading = in_heading;
    if (dy < 0) side_nxt.quad = (dx >= 0) ? 2'd0 : 2'd1;
    else        side_nxt.quad = (dx < 0) ? 2'd2 : 2'd3;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
    if (adv) begin
      adx_r  <= dx[16] ? 17'(-dx) : 17'(dx);
      ady_r  <= dy[16] ? 17'(-dy) : 17'(dy);
      side_r <= side_nxt;
    end
  end

  logic               vc;
  logic signed [ZW-1:0] zc;
  side_t              sc;

  btip_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(v0_r),
    .num(adx_r), .den(ady_r), .in_side(side_r),
    .out_vld(vc), .z_out(zc), .out_side(sc)
  );

  btip_post #(.ANGLE_FRAC_SCALE(ANGLE_FRAC_SCALE)) u_post (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(vc), .z_in(zc),
    .in_side(sc), .yaw_tol(yaw_tol_r), .rate(rate_r),
    .out_vld(out_valid), .bearing(out_bearing), .yaw_error(out_yaw_error),
    .aligned(out_aligned), .angular_speed(out_angular_speed)
  );

  `BTIP_ASSERT_NXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_bearing), "stalled output word changed")
  `BTIP_ASSERT_IMP(a_speed_sign, out_valid, out_angular_speed[15] == (out_yaw_error[17] && rate_r != '0), "turn command sign disagrees with error")
  `BTIP_ASSERT_IMP(a_bearing_range, out_valid, out_bearing <= 16'(360 * ANGLE_FRAC_SCALE) || ANGLE_FRAC_SCALE > 182, "bearing out of range")
endmodule

// ----- tb/bearing_turn_in_place_checker.sv -----
// ----------------------------------------------------------------------------
// Bearing result checker
// Watches both channels, predicts each result word and compares field by field.
// ----------------------------------------------------------------------------
module bearing_turn_in_place_checker #(
  parameter int ANGLE_FRAC_SCALE = 100
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [16:0] in_heading,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_bearing,
  input  logic signed [17:0] out_yaw_error,
  input  logic               out_aligned,
  input  logic signed [15:0] out_angular_speed,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count
);
  import btip_pkg::*;

  typedef struct packed {
    logic [15:0]        bearing;
    logic signed [17:0] yaw_error;
    logic               aligned;
    logic signed [15:0] angular_speed;
  } steer_t;

  steer_t steer_q[$];
  longint goal_x, goal_y, yaw_tol, turn_rate;

  assign pending_count = steer_q.size();

  function automatic longint shr_floor(longint v, int s);
    return (v >= 0) ? (v >>> s) : -(((-v) - 1) >>> s) - 1;
  endfunction

  // Vectoring CORDIC on the absolute offsets, result in 1/65536 degree.
  function automatic longint atan_deg16(longint num, longint den);
    longint x, y, z, xs, ys;
    x = den * 16384;
    y = num * 16384;
    z = 0;
    for (int i = 0; i < 23; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(atan_lut(i));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_lut(i));
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    return z;
  endfunction

  function automatic steer_t predict_steer(longint px, longint py, longint hd);
    longint dx, dy, a, b, base, err;
    steer_t r;
    dx = goal_x - px;
    dy = goal_y - py;
    b = 0;
    if (dx != 0 || dy != 0) begin
      a = (atan_deg16(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy) * ANGLE_FRAC_SCALE
           + 32768) >>> 16;
      if (py > goal_y) base = (px <= goal_x) ? 90 : 180;
      else base = (px > goal_x) ? 270 : 360;
      b = base * ANGLE_FRAC_SCALE - a;
      if (b < 0) b = 0;
    end
    b = b & 64'hFFFF;
    err = b - hd;
    r.bearing = b[15:0];
    r.yaw_error = err[17:0];
    r.aligned = ((err < 0 ? -err : err) <= yaw_tol);
    r.angular_speed = (err < 0) ? 16'(-turn_rate) : 16'(turn_rate);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    steer_t e;
    if (!rst_n) begin
      goal_x = 0; goal_y = 0; yaw_tol = 500; turn_rate = 100;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GOAL_X:    goal_x = longint'(signed'(cfg_data));
          REG_GOAL_Y:    goal_y = longint'(signed'(cfg_data));
          REG_YAW_TOL:   yaw_tol = cfg_data[14:0];
          REG_TURN_RATE: turn_rate = cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        steer_q.push_back(predict_steer(in_pos_x, in_pos_y, in_heading));
      if (out_valid && !out_stall) begin
        if (steer_q.size() == 0) begin
          // A word with nothing outstanding: report its bearing against none.
          report_mismatch("unexpected word bearing", out_bearing, -1);
        end else begin
          e = steer_q.pop_front();
          if (out_bearing !== e.bearing)
            report_mismatch("bearing", out_bearing, e.bearing);
          if (out_yaw_error !== e.yaw_error)
            report_mismatch("yaw_error", out_yaw_error, e.yaw_error);
          if (out_aligned !== e.aligned)
            report_mismatch("aligned", out_aligned, e.aligned);
          if (out_angular_speed !== e.angular_speed)
            report_mismatch("angular_speed", out_angular_speed, e.angular_speed);
        end
      end
    end
  end
endmodule

// ----- tb/bearing_turn_in_place_top_test.sv -----
// ----------------------------------------------------------------------------
// Turn-in-place bearing block testbench
// Drives position words under several goal settings with random idling and
// stalls; a checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module bearing_turn_in_place_top_test;
  import btip_pkg::*;

  // The pipeline is 27 stages deep; allow some slack when draining.
  localparam int DRAIN_CYCLES = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic signed [16:0] in_heading;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_bearing;
  logic signed [17:0] out_yaw_error;
  logic               out_aligned;
  logic signed [15:0] out_angular_speed;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count;
  int                 pending_count;
  // When set, neither side idles; this gives a long stretch at full rate.
  bit                 steady;

  bearing_turn_in_place_top u_dut (.*);

  bearing_turn_in_place_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random, about 13 times in a hundred, unless steady.
  always @(negedge clk)
    out_stall <= !steady && ($urandom_range(99) < 13);

  // Writes one configuration register; the port is only used while idle.
  // The valid line drops for one cycle between writes.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sends one position word, idling first at random, and waits for acceptance.
  task automatic send_position(logic [15:0] px, logic [15:0] py, logic [16:0] hd);
    while (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_pos_x   <= px;
    in_pos_y   <= py;
    in_heading <= hd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits until every predicted word has come back and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random heading, mostly in range, sometimes any 17-bit pattern.
  function automatic logic [16:0] rand_heading();
    if ($urandom_range(9) == 0) return 17'($urandom);
    return 17'($signed($urandom_range(72000)) - 36000);
  endfunction

  // Offsets near the goal most of the time so small angles and ties appear.
  function automatic logic [15:0] near(logic [15:0] c);
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return c + 16'($signed($urandom_range(8)) - 4);
      2: return c + 16'($signed($urandom_range(400)) - 200);
      default: return c;
    endcase
  endfunction

  initial begin
    logic [15:0] gx, gy;
    rst_n = 0; in_valid = 0; in_pos_x = 0; in_pos_y = 0; in_heading = 0;
    out_stall = 0; cfg_valid = 0; cfg_index = REG_GOAL_X; cfg_data = 0;
    steady = 0;
    repeat (5) @(negedge clk);
    rst_n = 1;

    // Directed words at the reset goal: at the goal, beside it, extremes.
    send_position(16'd0, 16'd0, 17'd0);
    send_position(16'd0, 16'd0, 17'h1FFFF);
    send_position(16'd5, 16'd0, 17'd27000);
    send_position(-16'sd5, 16'd0, 17'd9000);
    send_position(16'd0, 16'd7, 17'd0);
    send_position(16'd0, -16'sd7, 17'd36000);
    send_position(16'h7FFF, 16'h7FFF, -17'sd36000);
    send_position(16'h8000, 16'h8000, 17'd36000);
    send_position(16'h8000, 16'h7FFF, 17'h10000);
    send_position(16'h7FFF, 16'h8000, 17'h0FFFF);
    send_position(16'd3, 16'd4, 17'd22000);
    send_position(-16'sd3, 16'd4, 17'd14000);
    send_position(16'd3, -16'sd4, 17'd31000);
    send_position(-16'sd3, -16'sd4, 17'd5000);
    drain();

    // Extreme goal and register settings.
    write_reg(REG_GOAL_X, 16'h7FFF);
    write_reg(REG_GOAL_Y, 16'h8000);
    write_reg(REG_YAW_TOL, 16'd18000);
    write_reg(REG_TURN_RATE, 16'h7FFF);
    send_position(16'h8000, 16'h7FFF, 17'd0);
    send_position(16'h7FFF, 16'h8000, 17'd0);
    send_position(16'h8000, 16'h8000, -17'sd36000);
    send_position(16'h7FFF, 16'h7FFF, 17'd36000);
    drain();
    write_reg(REG_GOAL_X, 16'h8000);
    write_reg(REG_GOAL_Y, 16'h7FFF);
    write_reg(REG_YAW_TOL, 16'h7FFF);
    write_reg(REG_TURN_RATE, 16'd0);
    send_position(16'h7FFF, 16'h8000, 17'd100);
    send_position(16'h8000, 16'h7FFF, -17'sd100);
    drain();

    // Random phases, each with its own goal and settings.
    for (int ph = 0; ph < 6; ph++) begin
      gx = (ph == 0) ? 16'd0 : 16'($urandom);
      gy = (ph == 0) ? 16'd0 : 16'($urandom);
      write_reg(REG_GOAL_X, gx);
      write_reg(REG_GOAL_Y, gy);
      write_reg(REG_YAW_TOL, (ph == 1) ? 16'd0 : 16'($urandom_range(18000)));
      write_reg(REG_TURN_RATE, 16'($urandom_range(32767)));
      steady = (ph == 2);
      for (int k = 0; k < 100; k++) begin
        send_position(near(gx), near(gy), rand_heading());
        // The sender holds off once until every result is back.
        if (ph == 3 && k == 50) drain();
      end
      steady = 0;
      drain();
    end

    if (fail_count == 0)
      $display("PASS bearing_turn_in_place_top");
    else
      $display("FAIL bearing_turn_in_place_top");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL bearing_turn_in_place_top");
    $finish;
  end
endmodule
